// ----- sv/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants, types and codes for the Sv39 page-map block.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int STORE_ADDR_BITS = 18;
    localparam int LEVELS          = 3;

    localparam int PA_W          = 56;
    localparam int VA_W          = 39;
    localparam int FLAGS_W       = 10;
    localparam int PTE_W         = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int VPN_BITS      = 9;
    localparam int PTE_PPN_SHIFT = 10;
    localparam int PPN_W         = PA_W - PAGE_SHIFT;
    localparam int WORD_W        = STORE_ADDR_BITS - 3;
    localparam int STORE_WORDS   = 1 << WORD_W;
    localparam int PAGE_WORD_W   = STORE_ADDR_BITS - PAGE_SHIFT;
    localparam int LVL_W         = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int CNT_W         = 2;
    localparam int VA_EXT_W      = PAGE_SHIFT + VPN_BITS * LEVELS;
    localparam int CFG_IDX_W     = 2;

    localparam logic [PA_W-1:0] HEAP_LIMIT_RESET = PA_W'(262144);

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd2;

    localparam logic STATUS_MAPPED = 1'b0;
    localparam logic STATUS_OOM    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_ZERO,
        ST_LINK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [PA_W-1:0]  root;
        logic             ok;
        logic [PPN_W-1:0] page_num;
    } alloc_t;

    typedef struct packed {
        logic              we;
        logic [WORD_W-1:0] addr;
        logic [PTE_W-1:0]  data;
    } mem_wr_t;

endpackage

// ----- sv/spm_if.sv -----
// ----------------------------------------------------------------------------
// spm_if
// Request and response channels of the page-map block.
// ----------------------------------------------------------------------------
interface spm_req_if;
    logic                        valid;
    logic                        ready;
    logic [spm_pkg::VA_W-1:0]    virt_addr;
    logic [spm_pkg::PA_W-1:0]    phys_addr;
    logic [spm_pkg::FLAGS_W-1:0] leaf_flags;

    modport source (output valid, virt_addr, phys_addr, leaf_flags, input ready);
    modport sink   (input valid, virt_addr, phys_addr, leaf_flags, output ready);
endinterface

interface spm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [spm_pkg::CNT_W-1:0] tables_allocated;
    logic [spm_pkg::PA_W-1:0]  leaf_entry_addr;

    modport source (output valid, status, tables_allocated, leaf_entry_addr, input ready);
    modport sink   (input valid, status, tables_allocated, leaf_entry_addr, output ready);
endinterface

// ----- sv/spm_ram.sv -----
// ----------------------------------------------------------------------------
// spm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/spm_alloc.sv -----
// ----------------------------------------------------------------------------
// spm_alloc
// Configuration registers and page-aligned bump allocator for table pages.
// ----------------------------------------------------------------------------
module spm_alloc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spm_pkg::PA_W-1:0]        cfg_data,
    input  logic                            take,
    output spm_pkg::alloc_t                 alloc
);

    logic [spm_pkg::PA_W-1:0]  root_reg;
    logic [spm_pkg::PA_W-1:0]  limit_reg;
    logic [spm_pkg::PA_W-1:0]  ptr_reg;
    logic [spm_pkg::PA_W-1:0]  ptr_next;
    logic [spm_pkg::PPN_W:0]   start_num;
    logic [spm_pkg::PPN_W+1:0] end_num;

    // round up to the next page, then one page on
    always_comb
    begin
        start_num = (spm_pkg::PPN_W+1)'(ptr_reg[spm_pkg::PA_W-1:spm_pkg::PAGE_SHIFT])
                  + (spm_pkg::PPN_W+1)'(ptr_reg[spm_pkg::PAGE_SHIFT-1:0] != '0);
        end_num   = (spm_pkg::PPN_W+2)'(start_num) + (spm_pkg::PPN_W+2)'(1);
        ptr_next  = {end_num[spm_pkg::PPN_W-1:0], {spm_pkg::PAGE_SHIFT{1'b0}}};
        alloc.root     = root_reg;
        alloc.ok       = end_num <= (spm_pkg::PPN_W+2)'(
                             limit_reg[spm_pkg::PA_W-1:spm_pkg::PAGE_SHIFT]);
        alloc.page_num = start_num[spm_pkg::PPN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= '0;
            limit_reg <= spm_pkg::HEAP_LIMIT_RESET;
            ptr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spm_pkg::CFG_ROOT_TABLE: root_reg  <= cfg_data;
                spm_pkg::CFG_HEAP_START: ptr_reg   <= cfg_data;
                spm_pkg::CFG_HEAP_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
        else if (take)
        begin
            ptr_reg <= ptr_next;
        end
    end

endmodule

// ----- sv/spm_walker.sv -----
// ----------------------------------------------------------------------------
// spm_walker
// Table walk sequencer: clears the store, walks, links new pages, writes leaf.
// ----------------------------------------------------------------------------
module spm_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    spm_req_if.sink                       req,
    spm_rsp_if.source                     rsp,
    input  spm_pkg::alloc_t               alloc,
    output logic                          take,
    output spm_pkg::mem_wr_t              wr,
    output logic [spm_pkg::WORD_W-1:0]    rd_addr,
    input  logic [spm_pkg::PTE_W-1:0]     rd_data
);

    spm_pkg::state_t state_reg, state_next;

    logic [spm_pkg::VA_W-1:0]        va_reg, va_next;
    logic [spm_pkg::PA_W-1:0]        pa_reg, pa_next;
    logic [spm_pkg::FLAGS_W-1:0]     flags_reg, flags_next;
    logic [spm_pkg::PA_W-1:0]        table_reg, table_next;
    logic [spm_pkg::LVL_W-1:0]       level_reg, level_next;
    logic [spm_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [spm_pkg::PA_W-1:0]        entry_reg, entry_next;
    logic [spm_pkg::PPN_W-1:0]       page_reg, page_next;
    logic [spm_pkg::VPN_BITS-1:0]    zcnt_reg, zcnt_next;
    logic [spm_pkg::WORD_W-1:0]      ccnt_reg, ccnt_next;
    logic                            res_status_reg, res_status_next;
    logic [spm_pkg::PA_W-1:0]        res_addr_reg, res_addr_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_status_reg, out_status_next;
    logic [spm_pkg::CNT_W-1:0]       out_count_reg, out_count_next;
    logic [spm_pkg::PA_W-1:0]        out_addr_reg, out_addr_next;

    logic [spm_pkg::VA_EXT_W-1:0]    va_ext;
    logic [spm_pkg::VPN_BITS-1:0]    vpn;
    logic [spm_pkg::PA_W-1:0]        entry_addr;

    assign va_ext     = spm_pkg::VA_EXT_W'(va_reg);
    assign vpn        = va_ext[spm_pkg::PAGE_SHIFT + spm_pkg::VPN_BITS * level_reg
                               +: spm_pkg::VPN_BITS];
    assign entry_addr = table_reg + spm_pkg::PA_W'({vpn, 3'b000});

    assign req.ready            = (state_reg == spm_pkg::ST_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.tables_allocated = out_count_reg;
    assign rsp.leaf_entry_addr  = out_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        flags_next      = flags_reg;
        table_next      = table_reg;
        level_next      = level_reg;
        count_next      = count_reg;
        entry_next      = entry_reg;
        page_next       = page_reg;
        zcnt_next       = zcnt_reg;
        ccnt_next       = ccnt_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_addr_next   = out_addr_reg;
        take            = 1'b0;
        wr.we           = 1'b0;
        wr.addr         = entry_addr[spm_pkg::STORE_ADDR_BITS-1:3];
        wr.data         = '0;
        rd_addr         = entry_addr[spm_pkg::STORE_ADDR_BITS-1:3];

        unique case (state_reg)
            spm_pkg::ST_CLEAR:
            begin
                wr.we     = 1'b1;
                wr.addr   = ccnt_reg;
                ccnt_next = ccnt_reg + 1'b1;
                if (ccnt_reg == {spm_pkg::WORD_W{1'b1}})
                begin
                    state_next = spm_pkg::ST_IDLE;
                end
            end
            spm_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    va_next    = req.virt_addr;
                    pa_next    = req.phys_addr;
                    flags_next = req.leaf_flags;
                    table_next = alloc.root;
                    level_next = spm_pkg::LVL_W'(spm_pkg::LEVELS - 1);
                    count_next = '0;
                    state_next = spm_pkg::ST_LOOKUP;
                end
            end
            spm_pkg::ST_LOOKUP:
            begin
                entry_next = entry_addr;
                if (level_reg == '0)
                begin
                    wr.we           = 1'b1;
                    wr.data         = {{(spm_pkg::PTE_W - spm_pkg::PPN_W
                                         - spm_pkg::PTE_PPN_SHIFT){1'b0}},
                                       pa_reg[spm_pkg::PA_W-1:spm_pkg::PAGE_SHIFT],
                                       flags_reg[spm_pkg::FLAGS_W-1:1], 1'b1};
                    res_status_next = spm_pkg::STATUS_MAPPED;
                    res_addr_next   = entry_addr;
                    state_next      = spm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = spm_pkg::ST_CHECK;
                end
            end
            spm_pkg::ST_CHECK:
            begin
                if (rd_data[0])
                begin
                    table_next = {rd_data[spm_pkg::PTE_PPN_SHIFT+spm_pkg::PPN_W-1:
                                          spm_pkg::PTE_PPN_SHIFT],
                                  {spm_pkg::PAGE_SHIFT{1'b0}}};
                    level_next = level_reg - 1'b1;
                    state_next = spm_pkg::ST_LOOKUP;
                end
                else if (alloc.ok)
                begin
                    take       = 1'b1;
                    page_next  = alloc.page_num;
                    zcnt_next  = '0;
                    state_next = spm_pkg::ST_ZERO;
                end
                else
                begin
                    res_status_next = spm_pkg::STATUS_OOM;
                    res_addr_next   = '0;
                    state_next      = spm_pkg::ST_DONE;
                end
            end
            spm_pkg::ST_ZERO:
            begin
                wr.we     = 1'b1;
                wr.addr   = {page_reg[spm_pkg::PAGE_WORD_W-1:0], zcnt_reg};
                zcnt_next = zcnt_reg + 1'b1;
                if (zcnt_reg == {spm_pkg::VPN_BITS{1'b1}})
                begin
                    state_next = spm_pkg::ST_LINK;
                end
            end
            spm_pkg::ST_LINK:
            begin
                wr.we      = 1'b1;
                wr.addr    = entry_reg[spm_pkg::STORE_ADDR_BITS-1:3];
                wr.data    = {{(spm_pkg::PTE_W - spm_pkg::PPN_W
                                - spm_pkg::PTE_PPN_SHIFT){1'b0}},
                              page_reg, {(spm_pkg::PTE_PPN_SHIFT-1){1'b0}}, 1'b1};
                table_next = {page_reg, {spm_pkg::PAGE_SHIFT{1'b0}}};
                count_next = count_reg + 1'b1;
                level_next = level_reg - 1'b1;
                state_next = spm_pkg::ST_LOOKUP;
            end
            spm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = spm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spm_pkg::ST_CLEAR;
            ccnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ccnt_reg      <= ccnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        flags_reg      <= flags_next;
        table_reg      <= table_next;
        level_reg      <= level_next;
        count_reg      <= count_next;
        entry_reg      <= entry_next;
        page_reg       <= page_next;
        zcnt_reg       <= zcnt_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_addr_reg   <= out_addr_next;
    end

endmodule

// ----- sv/sv39_page_map_with_table_alloc.sv -----
// ----------------------------------------------------------------------------
// sv39_page_map_with_table_alloc
// Maps one Sv39 virtual page per request item, allocating table pages as needed.
//
// req carries virt_addr, phys_addr and leaf_flags; rsp returns status,
// tables_allocated and leaf_entry_addr, one item per request.
// cfg_we/cfg_index/cfg_data write root table address (0), heap start (1,
// also reloads the allocation pointer) and heap limit (2); write when idle.
// After reset the table store is swept to zero, one word a cycle, through
// all 32768 words; req.ready stays low until the sweep ends.
// Each upper level passes through LOOKUP (address) and CHECK (registered
// store read), the leaf entry is written in LOOKUP and DONE hands the
// result to the output register; a new item is taken only once the walker
// is back in IDLE.
// Each new table page takes 512 zeroing writes and a link write,
// all through the single write port of the store.
// One item is in the walk at a time; a finished result waits in the output
// register, and the next item is taken while it waits. A stalled rsp holds
// the following result in the walker until the output register frees.
// ----------------------------------------------------------------------------
module sv39_page_map_with_table_alloc (
    input  logic                          clk,
    input  logic                          rst_n,
    spm_req_if.sink                       req,
    spm_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spm_pkg::PA_W-1:0]      cfg_data
);

    spm_pkg::alloc_t                alloc;
    spm_pkg::mem_wr_t               wr;
    logic                           take;
    logic [spm_pkg::WORD_W-1:0]     rd_addr;
    logic [spm_pkg::PTE_W-1:0]      rd_data;

    spm_alloc u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .alloc     (alloc)
    );

    spm_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .alloc   (alloc),
        .take    (take),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spm_ram #(
        .WIDTH (spm_pkg::PTE_W),
        .DEPTH (spm_pkg::STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

endmodule
